// ===== rtl/core/npp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point on polygon: shared types and constants
// Coordinate widths, derived datapath widths and the edge transaction type.
// ----------------------------------------------------------------------------
package npp_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int VEC_W       = COORD_WIDTH + 1;     // edge and query deltas
	localparam int PROD_W      = 2 * VEC_W;           // one product
	localparam int DOT_W       = PROD_W + 1;          // signed dot product
	localparam int LEN_W       = PROD_W;              // squared edge length
	localparam int REM_W       = DOT_W;               // divider remainder
	localparam int MAG_W       = COORD_WIDTH + 2;     // multiplier bits of mul-div
	localparam int DSQ_W       = 2 * COORD_WIDTH + 1; // squared distance
	localparam int ROOT_W      = DSQ_W + 1;
	localparam int DIST_W      = COORD_WIDTH + 1;
	localparam int SQRT_STEPS  = COORD_WIDTH + 1;
	localparam int CNT_W       = $clog2(MAG_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_TDATA_W  = ((4 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * COORD_WIDTH + DIST_W + 7) / 8) * 8;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		point_t start;
		point_t stop;
		point_t query;
		logic   last;
	} edge_job_t;

endpackage

// ===== rtl/core/npp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point on polygon: front end
// Accepts vertices, tracks polygon context and issues edge transactions.
// ----------------------------------------------------------------------------
module npp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  npp_pkg::point_t     in_query,
	input  npp_pkg::point_t     in_vertex,
	input  logic                in_last,
	output logic                job_valid,
	input  logic                job_ready,
	output npp_pkg::edge_job_t  job
);

	logic               expect_q;
	logic               out_valid_q;
	logic               pend_valid_q;
	npp_pkg::edge_job_t out_job_q;
	npp_pkg::edge_job_t pend_job_q;
	npp_pkg::point_t    first_q;
	npp_pkg::point_t    prev_q;
	npp_pkg::point_t    query_q;
	logic               slot_free;
	logic               accept;

	assign slot_free = !out_valid_q || job_ready;
	assign in_ready  = !pend_valid_q && slot_free;
	assign accept    = in_valid && in_ready;
	assign job_valid = out_valid_q;
	assign job       = out_job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q     <= 1'b1;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && job_ready) out_valid_q <= 1'b0;
			// the closing edge of a last vertex is issued after the edge into it
			if (pend_valid_q && slot_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
			if (accept) begin
				if (expect_q) begin
					expect_q <= in_last;
					if (in_last) out_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
					if (in_last) begin
						pend_valid_q <= 1'b1;
						expect_q     <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && slot_free) out_job_q <= pend_job_q;
		if (accept) begin
			prev_q <= in_vertex;
			if (expect_q) begin
				query_q   <= in_query;
				first_q   <= in_vertex;
				out_job_q <= '{start: in_vertex, stop: in_vertex, query: in_query, last: 1'b1};
			end else begin
				out_job_q  <= '{start: prev_q, stop: in_vertex, query: query_q, last: 1'b0};
				pend_job_q <= '{start: in_vertex, stop: first_q, query: query_q, last: 1'b1};
			end
		end
	end

endmodule

// ===== rtl/core/npp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point on polygon: edge queue
// Short first-in first-out buffer between front end and edge engine.
// ----------------------------------------------------------------------------
module npp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  npp_pkg::edge_job_t  wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output npp_pkg::edge_job_t  rd_data
);

	npp_pkg::edge_job_t                entry_q [npp_pkg::QUEUE_DEPTH];
	logic [npp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [npp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [npp_pkg::QCNT_W-1:0]       count_q;
	logic                             push;
	logic                             pop;

	assign wr_ready = count_q != npp_pkg::QCNT_W'(npp_pkg::QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== rtl/core/npp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point on polygon: edge engine
// Projects the query onto each edge, keeps the best point, takes the root.
// ----------------------------------------------------------------------------
module npp_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  job_valid,
	output logic                                  job_ready,
	input  npp_pkg::edge_job_t                    job,
	output logic                                  m_valid,
	input  logic                                  m_ready,
	output npp_pkg::point_t                       m_point,
	output logic [npp_pkg::DIST_W-1:0]            m_dist
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_VEC, ST_DOT_A, ST_DOT_B, ST_LEN_A, ST_LEN_B, ST_CLASS,
		ST_DIV_A, ST_DIV_B, ST_POINT, ST_DIFF, ST_DSQ_A, ST_DSQ_B, ST_KEEP,
		ST_ROOT, ST_EMIT
	} state_t;

	typedef logic signed [npp_pkg::VEC_W-1:0] vec_t;
	typedef logic [npp_pkg::REM_W-1:0]        rem_t;
	typedef logic [npp_pkg::MAG_W-1:0]        mag_t;

	state_t                            state_q;
	npp_pkg::edge_job_t                job_q;
	vec_t                              vx_q, vy_q, wx_q, wy_q;
	logic signed [npp_pkg::PROD_W-1:0] acc_q;
	logic signed [npp_pkg::DOT_W-1:0]  c1_q;
	logic [npp_pkg::LEN_W-1:0]         c2_q;
	mag_t                              magx_q, magy_q, quox_q, quoy_q;
	rem_t                              remx_q, remy_q;
	logic [npp_pkg::CNT_W-1:0]         cnt_q;
	npp_pkg::point_t                   pt_q;
	logic [npp_pkg::DSQ_W-1:0]         d2_q, best_d2_q, root_x_q;
	npp_pkg::point_t                   best_pt_q;
	logic [npp_pkg::ROOT_W-1:0]        root_q, bit_q;
	logic                              m_valid_q;
	npp_pkg::point_t                   m_point_q;
	logic [npp_pkg::DIST_W-1:0]        m_dist_q;

	vec_t                              mul_a, mul_b;
	logic signed [npp_pkg::PROD_W-1:0] prod;
	logic signed [npp_pkg::PROD_W-1:0] psum;
	logic signed [npp_pkg::DOT_W-1:0]  dot_sum;
	rem_t                              num, den;
	logic [npp_pkg::REM_W+npp_pkg::MAG_W-1:0] stepx_a, stepy_a, stepx_b, stepy_b;
	vec_t                              vx_abs, vy_abs;
	mag_t                              offx, offy;
	logic [npp_pkg::ROOT_W-1:0]        root_trial;
	logic                              root_fit;
	logic                              better;

	function automatic logic [npp_pkg::REM_W+npp_pkg::MAG_W-1:0] div_shift(
		input rem_t r, input mag_t q, input rem_t d);
		rem_t r2;
		r2 = {r[npp_pkg::REM_W-2:0], 1'b0};
		if (r2 >= d) return {r2 - d, {q[npp_pkg::MAG_W-2:0], 1'b0} + 1'b1};
		return {r2, {q[npp_pkg::MAG_W-2:0], 1'b0}};
	endfunction

	function automatic logic [npp_pkg::REM_W+npp_pkg::MAG_W-1:0] div_add(
		input rem_t r, input mag_t q, input rem_t n, input rem_t d, input logic take);
		rem_t t;
		t = take ? r + n : r;
		if (t >= d) return {t - d, q + 1'b1};
		return {t, q};
	endfunction

	// one shared multiplier, operands picked by step
	always_comb begin
		case (state_q)
			ST_DOT_A: begin mul_a = wx_q; mul_b = vx_q; end
			ST_DOT_B: begin mul_a = wy_q; mul_b = vy_q; end
			ST_LEN_A: begin mul_a = vx_q; mul_b = vx_q; end
			ST_LEN_B: begin mul_a = vy_q; mul_b = vy_q; end
			ST_DSQ_A: begin mul_a = wx_q; mul_b = wx_q; end
			default:  begin mul_a = wy_q; mul_b = wy_q; end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign psum    = acc_q + prod;
	assign dot_sum = {acc_q[npp_pkg::PROD_W-1], acc_q} + {prod[npp_pkg::PROD_W-1], prod};

	assign num = rem_t'($unsigned(c1_q));
	assign den = {1'b0, c2_q};

	assign stepx_a = div_shift(remx_q, quox_q, den);
	assign stepy_a = div_shift(remy_q, quoy_q, den);
	assign stepx_b = div_add(remx_q, quox_q, num, den, magx_q[cnt_q]);
	assign stepy_b = div_add(remy_q, quoy_q, num, den, magy_q[cnt_q]);

	assign vx_abs = vx_q[npp_pkg::VEC_W-1] ? -vx_q : vx_q;
	assign vy_abs = vy_q[npp_pkg::VEC_W-1] ? -vy_q : vy_q;
	assign offx   = vx_q[npp_pkg::VEC_W-1] ? ~quox_q + 1'b1 : quox_q;
	assign offy   = vy_q[npp_pkg::VEC_W-1] ? ~quoy_q + 1'b1 : quoy_q;

	assign root_trial = root_q + bit_q;
	assign root_fit   = {1'b0, root_x_q} >= root_trial;
	assign better     = d2_q < best_d2_q;

	assign job_ready = state_q == ST_IDLE;
	assign m_valid   = m_valid_q;
	assign m_point   = m_point_q;
	assign m_dist    = m_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			job_q     <= '0;
			vx_q      <= '0; vy_q <= '0; wx_q <= '0; wy_q <= '0;
			acc_q     <= '0;
			c1_q      <= '0;
			c2_q      <= '0;
			magx_q    <= '0; magy_q <= '0; quox_q <= '0; quoy_q <= '0;
			remx_q    <= '0; remy_q <= '0;
			cnt_q     <= '0;
			pt_q      <= '0;
			d2_q      <= '0;
			best_d2_q <= '1;
			best_pt_q <= '0;
			root_x_q  <= '0;
			root_q    <= '0;
			bit_q     <= '0;
			m_valid_q <= 1'b0;
			m_point_q <= '0;
			m_dist_q  <= '0;
		end else begin
			if (m_valid_q && m_ready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						state_q <= ST_VEC;
					end
				end
				ST_VEC: begin
					vx_q    <= {job_q.stop.x[$bits(npp_pkg::coord_t)-1], job_q.stop.x}
						- {job_q.start.x[$bits(npp_pkg::coord_t)-1], job_q.start.x};
					vy_q    <= {job_q.stop.y[$bits(npp_pkg::coord_t)-1], job_q.stop.y}
						- {job_q.start.y[$bits(npp_pkg::coord_t)-1], job_q.start.y};
					wx_q    <= {job_q.query.x[$bits(npp_pkg::coord_t)-1], job_q.query.x}
						- {job_q.start.x[$bits(npp_pkg::coord_t)-1], job_q.start.x};
					wy_q    <= {job_q.query.y[$bits(npp_pkg::coord_t)-1], job_q.query.y}
						- {job_q.start.y[$bits(npp_pkg::coord_t)-1], job_q.start.y};
					state_q <= ST_DOT_A;
				end
				ST_DOT_A: begin
					acc_q   <= prod;
					state_q <= ST_DOT_B;
				end
				ST_DOT_B: begin
					c1_q    <= dot_sum;
					state_q <= ST_LEN_A;
				end
				ST_LEN_A: begin
					acc_q   <= prod;
					state_q <= ST_LEN_B;
				end
				ST_LEN_B: begin
					c2_q    <= npp_pkg::LEN_W'($unsigned(psum));
					state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					// clamp to start, clamp to end, or project
					if (c1_q[npp_pkg::DOT_W-1] || c1_q == '0) begin
						pt_q    <= job_q.start;
						state_q <= ST_DIFF;
					end else if (den <= num) begin
						pt_q    <= job_q.stop;
						state_q <= ST_DIFF;
					end else begin
						magx_q  <= {1'b0, vx_abs};
						magy_q  <= {1'b0, vy_abs};
						remx_q  <= '0;
						remy_q  <= '0;
						quox_q  <= '0;
						quoy_q  <= '0;
						cnt_q   <= npp_pkg::CNT_W'(npp_pkg::MAG_W - 1);
						state_q <= ST_DIV_A;
					end
				end
				ST_DIV_A: begin
					{remx_q, quox_q} <= stepx_a;
					{remy_q, quoy_q} <= stepy_a;
					state_q <= ST_DIV_B;
				end
				ST_DIV_B: begin
					{remx_q, quox_q} <= stepx_b;
					{remy_q, quoy_q} <= stepy_b;
					if (cnt_q == '0) state_q <= ST_POINT;
					else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_DIV_A;
					end
				end
				ST_POINT: begin
					pt_q.x  <= job_q.start.x + offx[npp_pkg::COORD_WIDTH-1:0];
					pt_q.y  <= job_q.start.y + offy[npp_pkg::COORD_WIDTH-1:0];
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					wx_q    <= {job_q.query.x[$bits(npp_pkg::coord_t)-1], job_q.query.x}
						- {pt_q.x[$bits(npp_pkg::coord_t)-1], pt_q.x};
					wy_q    <= {job_q.query.y[$bits(npp_pkg::coord_t)-1], job_q.query.y}
						- {pt_q.y[$bits(npp_pkg::coord_t)-1], pt_q.y};
					state_q <= ST_DSQ_A;
				end
				ST_DSQ_A: begin
					acc_q   <= prod;
					state_q <= ST_DSQ_B;
				end
				ST_DSQ_B: begin
					d2_q    <= npp_pkg::DSQ_W'($unsigned(psum));
					state_q <= ST_KEEP;
				end
				ST_KEEP: begin
					// strict compare: a tie keeps the earlier edge
					if (job_q.last) begin
						// park the winner in pt_q; the output register may still be busy
						root_x_q  <= better ? d2_q : best_d2_q;
						pt_q      <= better ? pt_q : best_pt_q;
						best_d2_q <= '1;
						best_pt_q <= '0;
						root_q    <= '0;
						bit_q     <= npp_pkg::ROOT_W'(1) << (2 * npp_pkg::COORD_WIDTH);
						cnt_q     <= npp_pkg::CNT_W'(npp_pkg::SQRT_STEPS - 1);
						state_q   <= ST_ROOT;
					end else begin
						if (better) begin
							best_d2_q <= d2_q;
							best_pt_q <= pt_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_ROOT: begin
					if (root_fit) begin
						root_x_q <= root_x_q - npp_pkg::DSQ_W'(root_trial);
						root_q   <= (root_q >> 1) + bit_q;
					end else begin
						root_q   <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (cnt_q == '0) state_q <= ST_EMIT;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (!m_valid_q || m_ready) begin
						m_valid_q <= 1'b1;
						m_point_q <= pt_q;
						m_dist_q  <= root_q[npp_pkg::DIST_W-1:0];
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_A |-> (remx_q < den && remy_q < den))
		else $error("divider remainder not below squared edge length");

	a_quo_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POINT |-> (quox_q <= magx_q && quoy_q <= magy_q))
		else $error("projection offset exceeds edge extent");

	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> $onehot(bit_q))
		else $error("square root trial bit lost");

	a_best_reset: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> best_d2_q == '1)
		else $error("best distance not rearmed after last edge");

endmodule

// ===== rtl/core/nearest_point_on_polygon_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point on polygon boundary
// Streams polygon vertices in and emits the closest boundary point per polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Drive one vertex per s_ transaction; s_tlast marks the final vertex. The
//   query point is taken from the first vertex of each polygon and ignored on
//   the rest. Each edge, the closing edge included, is projected onto in turn.
//   After the final vertex one m_ transaction carries the nearest point and
//   the floor of its Euclidean distance, in signed Q12.4 and unsigned Q13.4.
// Flow:
//   An edge that clamps to an end point skips the mul-div step; one that
//   projects runs the x and y mul-div units side by side over 18 quotient
//   bits, a shift state and an add state per bit. The last edge also runs
//   the bit-serial square root. The front end takes a vertex per cycle while
//   the 2-deep edge queue has room and no closing edge waits to be issued.
// Reset:
//   arst_n clears the polygon context, the queue and the best-so-far record.
// Back-pressure:
//   A result waits in the output register while m_tready is low; the engine
//   keeps working on later edges until its next result is ready to go out.
// ----------------------------------------------------------------------------
module nearest_point_on_polygon_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// query_x, query_y, vertex_x, vertex_y
	input  logic [npp_pkg::IN_TDATA_W-1:0]         s_tdata,
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// nearest_x, nearest_y, distance, zero fill
	output logic [npp_pkg::OUT_TDATA_W-1:0]        m_tdata
);

	localparam int CW = npp_pkg::COORD_WIDTH;

	npp_pkg::point_t    query;
	npp_pkg::point_t    vertex;
	npp_pkg::edge_job_t fe_job;
	npp_pkg::edge_job_t q_job;
	logic               fe_valid, fe_ready;
	logic               q_valid, q_ready;
	npp_pkg::point_t    res_point;
	logic [npp_pkg::DIST_W-1:0] res_dist;

	// unpack the input transaction
	assign query.x  = s_tdata[CW-1:0];
	assign query.y  = s_tdata[2*CW-1:CW];
	assign vertex.x = s_tdata[3*CW-1:2*CW];
	assign vertex.y = s_tdata[4*CW-1:3*CW];

	npp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_query  (query),
		.in_vertex (vertex),
		.in_last   (s_tlast),
		.job_valid (fe_valid),
		.job_ready (fe_ready),
		.job       (fe_job)
	);

	npp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fe_valid),
		.wr_ready (fe_ready),
		.wr_data  (fe_job),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_job)
	);

	npp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_point   (res_point),
		.m_dist    (res_dist)
	);

	// pack the result transaction, zero fill on top
	assign m_tdata = {
		(npp_pkg::OUT_TDATA_W - 2 * CW - npp_pkg::DIST_W)'(0),
		res_dist, res_point.y, res_point.x
	};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point on polygon: block-level testbench
// Streams polygons into the core, predicts the nearest boundary point and its
// distance for each one, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic [npp_pkg::COORD_WIDTH-1:0] px;
		logic [npp_pkg::COORD_WIDTH-1:0] py;
		logic [npp_pkg::DIST_W-1:0]      distance;
	} nearest_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [npp_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [npp_pkg::OUT_TDATA_W-1:0] m_tdata;

	nearest_t expected_q[$];
	int       mismatches;
	bit       stall_enable;
	bit       sink_hold;
	bit       idle_enable;

	// predictor state, coordinates held as 64-bit sign-extended values
	longint   first_x, first_y, prev_x, prev_y, query_x, query_y;
	longint   best_x, best_y;
	longint unsigned best_d2;
	bit       want_first;

	nearest_point_on_polygon_core uut (.*);

	always #4 clk = ~clk;

	function automatic longint unsigned mul_div_trunc(longint unsigned num,
			longint unsigned m, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = npp_pkg::COORD_WIDTH + 1; i >= 0; i--) begin
			q = q << 1;
			r = r << 1;
			if (r >= den) begin
				r -= den;
				q++;
			end
			if (m[i]) begin
				r += num;
				if (r >= den) begin
					r -= den;
					q++;
				end
			end
		end
		return q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint along_edge(longint unsigned c1, longint unsigned c2,
			longint v);
		longint unsigned q;
		q = mul_div_trunc(c1, (v < 0) ? -v : v, c2);
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	// project the held query onto one edge and keep the closer point
	function automatic void project_edge(longint sx, longint sy, longint ex,
			longint ey);
		longint vx, vy, c1, px, py, dx, dy;
		longint unsigned c2, d2;
		vx = ex - sx;
		vy = ey - sy;
		c1 = (query_x - sx) * vx + (query_y - sy) * vy;
		c2 = vx * vx + vy * vy;
		if (c1 <= 0) begin
			px = sx;
			py = sy;
		end else if (c2 <= longint'(c1)) begin
			px = ex;
			py = ey;
		end else begin
			px = sx + along_edge(c1, c2, vx);
			py = sy + along_edge(c1, c2, vy);
		end
		dx = query_x - px;
		dy = query_y - py;
		d2 = dx * dx + dy * dy;
		if (d2 < best_d2) begin
			best_d2 = d2;
			best_x = px;
			best_y = py;
		end
	endfunction

	function automatic void predict_vertex(npp_pkg::coord_t qx, npp_pkg::coord_t qy,
			npp_pkg::coord_t vx, npp_pkg::coord_t vy, logic last);
		nearest_t r;
		if (want_first) begin
			query_x = qx;
			query_y = qy;
			first_x = vx;
			first_y = vy;
			want_first = 0;
		end else begin
			project_edge(prev_x, prev_y, vx, vy);
		end
		prev_x = vx;
		prev_y = vy;
		if (last) begin
			project_edge(vx, vy, first_x, first_y);
			r.px = best_x[npp_pkg::COORD_WIDTH-1:0];
			r.py = best_y[npp_pkg::COORD_WIDTH-1:0];
			r.distance = npp_pkg::DIST_W'(int_sqrt(best_d2));
			expected_q = {expected_q, r};
			best_d2 = 64'h1_FFFF_FFFF;
			best_x = 0;
			best_y = 0;
			want_first = 1;
		end
	endfunction

	// offer one vertex transaction, with a random gap first, and wait for it
	task automatic send_vertex(npp_pkg::coord_t qx, npp_pkg::coord_t qy,
			npp_pkg::coord_t vx, npp_pkg::coord_t vy, logic last);
		while (idle_enable && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vy, vx, qy, qx};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_vertex(qx, qy, vx, vy, last);
	endtask

	function automatic npp_pkg::coord_t rand_coord(int span);
		if (span == 0) return npp_pkg::coord_t'($urandom);
		return npp_pkg::coord_t'($urandom_range(2 * span) - span);
	endfunction

	task automatic send_polygon(int nverts, int span);
		npp_pkg::coord_t qx, qy;
		qx = rand_coord(span);
		qy = rand_coord(span);
		for (int i = 0; i < nverts; i++)
			send_vertex(i == 0 ? qx : rand_coord(0), i == 0 ? qy : rand_coord(0),
				rand_coord(span), rand_coord(span), i == nverts - 1);
	endtask

	// extremes, single vertex, degenerate edges and end clamps
	task automatic test_directed();
		send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1);
		send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1);
		send_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b1);
		send_vertex(16'sh0010, 16'sh0010, 16'sh0000, 16'sh0000, 1'b0);
		send_vertex(16'shFFFF, 16'shFFFF, 16'sh0000, 16'sh0000, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
		send_vertex(16'sh0035, 16'sh0100, 16'sh0000, 16'sh0000, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100, 1'b1);
		send_vertex(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_vertex(16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh8000, 1'b1);
		send_vertex(16'sh0000, 16'sh0000, 16'shFFF0, 16'sh0010, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh0010, 16'shFFF0, 1'b1);
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 700) begin
			int n;
			// run the opening stretch with no idling on either side
			idle_enable = sent >= 200;
			stall_enable = sent >= 200;
			n = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
			case ($urandom_range(3))
				0: send_polygon(n, 0);
				1: send_polygon(n, 64);
				default: send_polygon(n, 4096);
			endcase
			sent += n;
		end
	endtask

	// hold the result side for a long stretch while vertices keep coming
	task automatic test_backpressure();
		sink_hold = 1;
		fork
			for (int k = 0; k < 10; k++) send_polygon(3, 2048);
			begin
				repeat (3000) @(posedge clk);
				sink_hold = 0;
			end
		join
	endtask

	// random stalls on the result side
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= !sink_hold && !(stall_enable && $urandom_range(99) < 10);
		end
	end

	// check every result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			nearest_t got, want;
			got = {m_tdata[npp_pkg::COORD_WIDTH-1:0],
				m_tdata[2*npp_pkg::COORD_WIDTH-1:npp_pkg::COORD_WIDTH],
				m_tdata[2*npp_pkg::COORD_WIDTH+npp_pkg::DIST_W-1:2*npp_pkg::COORD_WIDTH]};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h d=%h", got.px, got.py,
						got.distance);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h d=%h got x=%h y=%h d=%h",
							want.px, want.py, want.distance, got.px, got.py,
							got.distance);
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		mismatches = 0;
		stall_enable = 0;
		idle_enable = 0;
		sink_hold = 0;
		want_first = 1;
		best_d2 = 64'h1_FFFF_FFFF;
		best_x = 0;
		best_y = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_enable = 1;
		idle_enable = 1;
		test_random();
		test_backpressure();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
